### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// An expression that holds at every clock edge out of reset.
`define NPSD_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// A consequent that holds in the same cycle as its antecedent.
`define NPSD_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hdl/npsd_pkg.sv
// ----------------------------------------------------------------------------
// npsd_pkg
// Types, codes and a shared function of the 2D nearest point search block.
// ----------------------------------------------------------------------------
package npsd_pkg;

  localparam int unsigned COORD_BITS      = 16;
  localparam int unsigned INDEX_BITS      = 8;
  localparam int unsigned SQ_W            = 2 * COORD_BITS + 1;
  localparam int unsigned DIST_W          = 2 * COORD_BITS + 2;
  localparam int unsigned NPSD_MAX_POINTS = 256;
  localparam int unsigned NPSD_CNT_W      = $clog2(NPSD_MAX_POINTS + 1);

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_LOAD   = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic [1:0]                   command;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
  } npsd_in_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic [INDEX_BITS-1:0]        nearest_index;
    logic signed [COORD_BITS-1:0] nearest_x;
    logic signed [COORD_BITS-1:0] nearest_y;
    logic [DIST_W-1:0]            distance_squared;
  } npsd_out_t;

  // Write strobe for the point store, broadcast to every cell.
  typedef struct packed {
    logic                         en;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } npsd_wr_t;

  // Query token walking down the chain. The pending part holds the squares
  // worked out by the previous cell; the best part is the winner so far.
  typedef struct packed {
    logic                         vld;
    logic signed [COORD_BITS-1:0] qx;
    logic signed [COORD_BITS-1:0] qy;
    logic                         pend_vld;
    logic [SQ_W-1:0]              sq_x;
    logic [SQ_W-1:0]              sq_y;
    logic [INDEX_BITS-1:0]        pend_idx;
    logic signed [COORD_BITS-1:0] pend_x;
    logic signed [COORD_BITS-1:0] pend_y;
    logic                         have;
    logic [DIST_W-1:0]            best_d;
    logic [INDEX_BITS-1:0]        best_idx;
    logic signed [COORD_BITS-1:0] best_x;
    logic signed [COORD_BITS-1:0] best_y;
  } npsd_tok_t;

  // Folds the pending candidate into the best so far. A strict compare keeps
  // the lowest index on ties, since candidates arrive in index order.
  function automatic npsd_tok_t tok_fold(npsd_tok_t t);
    npsd_tok_t         r;
    logic [DIST_W-1:0] d;
    r = t;
    d = DIST_W'(t.sq_x) + DIST_W'(t.sq_y);
    if (t.pend_vld && (!t.have || (d < t.best_d))) begin
      r.have     = 1'b1;
      r.best_d   = d;
      r.best_idx = t.pend_idx;
      r.best_x   = t.pend_x;
      r.best_y   = t.pend_y;
    end
    r.pend_vld = 1'b0;
    return r;
  endfunction

endpackage

### hdl/nearest_point_search_2d_core.sv
// ----------------------------------------------------------------------------
// nearest_point_search_2d_core
// Brute-force nearest neighbour search over a stored set of 2D points.
// ----------------------------------------------------------------------------
// Use: items arrive on the input channel (in_valid_i / in_stall_o) and every
// item yields exactly one result item on the output channel (out_valid_o /
// out_stall_i). A clear item empties the set, a load item appends a point to
// the store unless it is full, and a query item returns the first stored
// point with the smallest squared distance, its index and that distance.
// Timing: clear, load and a query on an empty set are answered in the next
// cycle from the output register, and a further item is taken as soon as
// the output does not stall. A query with points stored sends a query token
// down the chain of cells, one cell per cycle, and no other item is taken
// while it walks or while its result waits for the output register.
// Reset empties the set; stored coordinates are not cleared, as only slots
// below the point count ever take part in a search.
// A stalled result is held in the output register; the block then takes no
// further item until that result has gone.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_point_search_2d_core #(
  parameter int unsigned MAX_POINTS = npsd_pkg::NPSD_MAX_POINTS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  npsd_pkg::npsd_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output npsd_pkg::npsd_out_t out_data_o
);
  import npsd_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_POINTS);

  state_e           state_q;
  state_e           state_d;
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  npsd_tok_t        entry_q;
  npsd_tok_t        entry_d;
  npsd_tok_t        chain_w [MAX_POINTS+1];
  npsd_tok_t        last_fold;
  npsd_wr_t         wr;
  npsd_out_t        imm_res;
  npsd_out_t        hold_q;
  npsd_out_t        out_q;
  logic             out_valid_q;
  logic             out_free;
  logic             in_fire;
  logic             is_full;
  logic             start_req;
  logic             imm_push;
  logic             hold_push;
  logic             hold_load;
  logic             tok_out_vld;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_fire  = in_valid_i && !in_stall_o;
  assign is_full  = (count_q == FULL_COUNT);
  assign imm_push = in_fire && !start_req;

  // Command decoder: loads, clears and empty queries are answered at once;
  // a query on a non-empty set launches a token into the chain.
  always_comb begin
    imm_res   = '0;
    start_req = 1'b0;
    count_d   = count_q;
    wr.en     = 1'b0;
    wr.x      = in_data_i.coord_x;
    wr.y      = in_data_i.coord_y;
    unique case (in_data_i.command)
      CMD_CLEAR: begin
        if (in_fire) begin
          count_d = '0;
        end
      end
      CMD_LOAD: begin
        if (is_full) begin
          imm_res.status = STATUS_FULL;
        end else begin
          imm_res.nearest_index = INDEX_BITS'(count_q);
          imm_res.nearest_x     = in_data_i.coord_x;
          imm_res.nearest_y     = in_data_i.coord_y;
          wr.en                 = in_fire;
          if (in_fire) begin
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      CMD_QUERY: begin
        if (count_q == '0) begin
          imm_res.status = STATUS_EMPTY;
        end else begin
          start_req = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    entry_d = '0;
    if (in_fire && start_req) begin
      entry_d.vld = 1'b1;
      entry_d.qx  = in_data_i.coord_x;
      entry_d.qy  = in_data_i.coord_y;
    end
  end

  // Next-state logic of the query sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && start_req) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chain_w[MAX_POINTS].vld) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs of the query sequencer.
  always_comb begin
    in_stall_o = 1'b1;
    hold_push  = 1'b0;
    hold_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = !out_free;
      end
      ST_SCAN: begin
        hold_load = chain_w[MAX_POINTS].vld;
      end
      ST_DRAIN: begin
        hold_push = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      entry_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      entry_q <= entry_d;
    end
  end

  // The chain: token enters at cell 0 and leaves after the last cell.
  assign chain_w[0] = entry_q;

  for (genvar gi = 0; gi < MAX_POINTS; gi++) begin : g_cell
    npsd_cell #(
      .CNT_W (CNT_W),
      .IDX   (gi)
    ) u_cell (
      .count_i (count_q),
      .wr_i    (wr),
      .tok_i   (chain_w[gi]),
      .tok_o   (chain_w[gi+1]),
      .clk_i   (clk_i),
      .rst_ni  (rst_ni)
    );
  end

  // The last cell's candidate still has to be compared.
  assign last_fold   = tok_fold(chain_w[MAX_POINTS]);
  assign tok_out_vld = chain_w[MAX_POINTS].vld;

  always_ff @(posedge clk_i) begin
    if (hold_load) begin
      hold_q.status           <= STATUS_OK;
      hold_q.nearest_index    <= last_fold.best_idx;
      hold_q.nearest_x        <= last_fold.best_x;
      hold_q.nearest_y        <= last_fold.best_y;
      hold_q.distance_squared <= last_fold.best_d;
    end
  end

  // Output register: filled by an immediate answer or by a finished query.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= imm_push || hold_push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (imm_push) begin
        out_q <= imm_res;
      end else if (hold_push) begin
        out_q <= hold_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `NPSD_ASSERT_ALWAYS(a_count_bound, count_q <= FULL_COUNT, "point count beyond store size")
  `NPSD_ASSERT_IMPLIES(a_token_in_scan, tok_out_vld, state_q == ST_SCAN, "token outside a scan")
  `NPSD_ASSERT_IMPLIES(a_token_found, tok_out_vld, last_fold.have, "query without a candidate")

endmodule

### hdl/npsd_cell.sv
// ----------------------------------------------------------------------------
// npsd_cell
// One slot of the point chain: stores a point and scores the passing query.
// ----------------------------------------------------------------------------
module npsd_cell #(
  parameter int unsigned CNT_W = npsd_pkg::NPSD_CNT_W,
  parameter int unsigned IDX   = 0
) (
  input  logic                [CNT_W-1:0] count_i,
  input  npsd_pkg::npsd_wr_t              wr_i,
  input  npsd_pkg::npsd_tok_t             tok_i,
  output npsd_pkg::npsd_tok_t             tok_o,
  input  logic                            clk_i,
  input  logic                            rst_ni
);
  import npsd_pkg::*;

  localparam logic [CNT_W-1:0]      SLOT    = CNT_W'(IDX);
  localparam logic [INDEX_BITS-1:0] SLOT_LO = INDEX_BITS'(IDX);

  logic signed [COORD_BITS-1:0] px_q;
  logic signed [COORD_BITS-1:0] py_q;
  logic signed [COORD_BITS:0]   dx;
  logic signed [COORD_BITS:0]   dy;
  logic signed [SQ_W-1:0]       sqx_full;
  logic signed [SQ_W-1:0]       sqy_full;
  npsd_tok_t                    tok_d;
  npsd_tok_t                    tok_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (count_i == SLOT)) begin
      px_q <= wr_i.x;
      py_q <= wr_i.y;
    end
  end

  // The previous cell's squares are added and compared here, while this
  // cell's own squares go into the token register for the next cell.
  always_comb begin
    dx       = (COORD_BITS + 1)'(tok_i.qx) - (COORD_BITS + 1)'(px_q);
    dy       = (COORD_BITS + 1)'(tok_i.qy) - (COORD_BITS + 1)'(py_q);
    sqx_full = dx * dx;
    sqy_full = dy * dy;
    tok_d          = tok_fold(tok_i);
    tok_d.pend_vld = (SLOT < count_i);
    tok_d.sq_x     = sqx_full;
    tok_d.sq_y     = sqy_full;
    tok_d.pend_idx = SLOT_LO;
    tok_d.pend_x   = px_q;
    tok_d.pend_y   = py_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule
